// ===== hw/rtl/abtwa_pkg.sv =====
// Shared types and constants for the address block table with aging.
// Used by abtwa_cell and address_block_table_with_aging; no dependencies.
`default_nettype none

package abtwa_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 64;

  // field widths
  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 7;

  localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = LIMIT_W'(60);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_FULL        = 2'd2
  } status_t;

  // request held steady for the whole scan
  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic               blk;
    logic               check;
    logic [TIME_W-1:0]  now;
    logic [LIMIT_W-1:0] limit;
  } req_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic               active;
    logic               found;
    logic               free_seen;
    logic [COUNT_W-1:0] count;
  } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/abtwa_cell.sv =====
// One table slot: address, blocked mark, stamp and valid bit.
// Acts when the scan token passes and hands the token on. Uses abtwa_pkg.
`default_nettype none

module abtwa_cell
  import abtwa_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire req_t   req,
  input  wire logic   commit,
  input  wire token_t token_in,
  output token_t      token_out
);

  logic              valid;
  logic              reserve;
  logic [KEY_W-1:0]  address;
  logic              blocked;
  logic [TIME_W-1:0] stamp;

  logic              match;
  logic              aged;
  logic [TIME_W-1:0] age;
  logic              upd_we;
  logic              fill_we;
  logic              clr;
  logic              reserve_set;
  logic [COUNT_W-1:0] count_inc;
  token_t            token_next;

  // per-slot compare and age check
  always_comb begin
    age         = req.now - stamp;
    match       = valid && (address == req.key);
    aged        = valid && (age >= {{(TIME_W-LIMIT_W){1'b0}}, req.limit});
    upd_we      = token_in.active && match &&
                  ((req.cmd == CMD_TOUCH) || ((req.cmd == CMD_INSERT) && req.check));
    clr         = token_in.active &&
                  (((req.cmd == CMD_REMOVE) && match) || ((req.cmd == CMD_SWEEP) && aged));
    reserve_set = token_in.active && (req.cmd == CMD_INSERT) && !valid &&
                  !token_in.free_seen;
    fill_we     = commit && reserve;
    count_inc   = (token_in.count == COUNT_MAX) ? token_in.count
                                                 : token_in.count + COUNT_W'(1);
  end

  // token update
  always_comb begin
    token_next           = token_in;
    token_next.found     = token_in.found || (match && (req.cmd != CMD_SWEEP));
    token_next.free_seen = token_in.free_seen || reserve_set;
    token_next.count     = clr ? count_inc : token_in.count;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      reserve   <= 1'b0;
      token_out <= '0;
    end else begin
      token_out <= token_next;
      if (token_in.active) begin
        reserve <= reserve_set;
      end
      if (clr) begin
        valid <= 1'b0;
      end else if (fill_we) begin
        valid <= 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (fill_we) begin
      address <= req.key;
    end
    if (fill_we || upd_we) begin
      blocked <= req.blk;
      stamp   <= req.now;
    end
  end

  // blocked mark is held for the table; not reported by any command
  logic unused_blocked;
  assign unused_blocked = blocked;

endmodule

`default_nettype wire

// ===== hw/rtl/address_block_table_with_aging.sv =====
// Address block table with aging: top level with request register, scan
// control and result register. Uses abtwa_pkg and abtwa_cell.
// Flow: the request register, then a launch register; the scan token then
// walks the cell row one slot per cycle, then the finish step places an insert
// and loads the result once the result register is free; only then is a new request taken.
// Reset: synchronous; all slots invalid, age_limit back to 60 seconds.
`default_nettype none

module address_block_table_with_aging
  import abtwa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               age_limit_we,
  input  wire logic [LIMIT_W-1:0] age_limit_data,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [KEY_W-1:0]   address_key,
  input  wire logic               block_flag,
  input  wire logic               check_existing,
  input  wire logic [TIME_W-1:0]  now_seconds,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [1:0]              status,
  output logic [COUNT_W-1:0]      removed_count
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [LIMIT_W-1:0] age_limit;
  req_t               req;
  logic               launch;
  token_t             fin;
  token_t             chain [0:TABLE_ENTRIES];
  logic               accept;
  logic               out_free;
  logic               load;
  logic               commit;
  status_t            status_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load     = (state == S_FINISH) && out_free;
  assign commit   = load && (req.cmd == CMD_INSERT) && !fin.found && fin.free_seen;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_LIMIT_RESET;
    end else if (age_limit_we) begin
      age_limit <= age_limit_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (accept) begin
      req.cmd   <= cmd_t'(command);
      req.key   <= address_key;
      req.blk   <= block_flag;
      req.check <= check_existing;
      req.now   <= now_seconds;
      req.limit <= age_limit;
    end
  end

  // cell row
  assign chain[0] = '{active: launch, found: 1'b0, free_seen: 1'b0, count: '0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    abtwa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .commit   (commit),
      .token_in (chain[i]),
      .token_out(chain[i+1])
    );
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (chain[TABLE_ENTRIES].active) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && chain[TABLE_ENTRIES].active) begin
      fin <= chain[TABLE_ENTRIES];
    end
  end

  // result status
  always_comb begin
    status_next = ST_OK;
    if ((req.cmd != CMD_SWEEP) && !fin.found) begin
      if (req.cmd == CMD_INSERT) begin
        status_next = fin.free_seen ? ST_OK : ST_FULL;
      end else begin
        status_next = ST_NOT_PRESENT;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found         <= fin.found;
      status        <= status_next;
      removed_count <= fin.count;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while a scan is under way");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK)
    else $error("found result reports a failing status");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> removed_count <= COUNT_W'(1))
    else $error("lookup command removed more than one entry");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result loaded outside the finish step");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for address_block_table_with_aging: a queue-fed
// request driver, a result monitor and an in-bench table predictor.
// Depends on abtwa_pkg and the address_block_table_with_aging RTL.
`timescale 1ns / 100ps

module tb_top;
  import abtwa_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic              blk;
    logic              chk;
    logic [TIME_W-1:0] now;
  } table_req_t;

  typedef struct {
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] removed;
  } table_outcome_t;

  localparam int KEY_POOL = 96;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               age_limit_we   = 1'b0;
  logic [LIMIT_W-1:0] age_limit_data = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         command        = '0;
  logic [KEY_W-1:0]   address_key    = '0;
  logic               block_flag     = 1'b0;
  logic               check_existing = 1'b0;
  logic [TIME_W-1:0]  now_seconds    = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               found;
  logic [1:0]         status;
  logic [COUNT_W-1:0] removed_count;

  // predicted table contents and aging limit
  logic               slot_live [TABLE_ENTRIES];
  logic [KEY_W-1:0]   slot_key  [TABLE_ENTRIES];
  logic               slot_blk  [TABLE_ENTRIES];
  logic [TIME_W-1:0]  slot_stamp[TABLE_ENTRIES];
  logic [LIMIT_W-1:0] age_limit_m = AGE_LIMIT_RESET;

  table_req_t     pending_q[$];
  table_outcome_t outcome_q[$];
  table_req_t     on_wire;

  logic [KEY_W-1:0]  key_pool[KEY_POOL];
  logic [TIME_W-1:0] clock_s = '0;
  int idle_pct     = 27;
  int error_count  = 0;
  int result_count = 0;
  int cmd_count[4] = '{0, 0, 0, 0};
  int full_count   = 0;
  int aged_count   = 0;

  address_block_table_with_aging DUT (
    .clk            (clk),
    .rst            (rst),
    .age_limit_we   (age_limit_we),
    .age_limit_data (age_limit_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .address_key    (address_key),
    .block_flag     (block_flag),
    .check_existing (check_existing),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .status         (status),
    .removed_count  (removed_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Table predictor: applies one request, returns the result it must give
  function automatic table_outcome_t apply_command(input table_req_t r);
    table_outcome_t res;
    int hit;
    int spare;
    res.found   = 1'b0;
    res.status  = ST_OK;
    res.removed = '0;
    hit   = -1;
    spare = -1;
    if (r.cmd == CMD_SWEEP) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_live[i] && TIME_W'(r.now - slot_stamp[i]) >= TIME_W'(age_limit_m)) begin
          slot_live[i] = 1'b0;
          if (res.removed != COUNT_MAX) res.removed++;
        end
      end
      return res;
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_key[i] == r.key) hit = i;
      if (!slot_live[i]) spare = i;
    end
    res.found = (hit >= 0);
    case (r.cmd)
      CMD_TOUCH: begin
        if (hit >= 0) begin
          slot_blk[hit]   = r.blk;
          slot_stamp[hit] = r.now;
        end else begin
          res.status = ST_NOT_PRESENT;
        end
      end
      CMD_INSERT: begin
        if (hit >= 0) begin
          if (r.chk) begin
            slot_blk[hit]   = r.blk;
            slot_stamp[hit] = r.now;
          end
        end else if (spare < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_live[spare]  = 1'b1;
          slot_key[spare]   = r.key;
          slot_blk[spare]   = r.blk;
          slot_stamp[spare] = r.now;
        end
      end
      default: begin
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          res.removed    = 1;
        end else begin
          res.status = ST_NOT_PRESENT;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 40)
      $display("%0t: mismatch on %s in result %0d: got %0d, expected %0d",
               $realtime, what, result_count, got, want);
    error_count++;
  endtask

  task automatic queue_request(input cmd_t c, input logic [KEY_W-1:0] k, input logic b,
                               input logic ch, input logic [TIME_W-1:0] t);
    table_req_t r;
    r.cmd = c;
    r.key = k;
    r.blk = b;
    r.chk = ch;
    r.now = t;
    pending_q.push_back(r);
  endtask

  // Random requests on a moving clock; optionally opens with a table fill
  task automatic queue_random(input int count, input bit fill_first);
    cmd_t c;
    logic [KEY_W-1:0] k;
    int pick;
    int n;
    n = 0;
    if (fill_first) begin
      for (int i = 0; i < 70; i++) begin
        clock_s += $urandom_range(0, 3);
        queue_request(CMD_INSERT, key_pool[i], 1'($urandom), 1'($urandom), clock_s);
      end
      n = 70;
    end
    for (; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)      c = CMD_INSERT;
      else if (pick < 65) c = CMD_TOUCH;
      else if (pick < 85) c = CMD_REMOVE;
      else                c = CMD_SWEEP;
      if ($urandom_range(9) == 0) k = $urandom;
      else                        k = key_pool[$urandom_range(KEY_POOL - 1)];
      // mostly small steps, some long jumps, a few steps back in time
      pick = $urandom_range(49);
      if (pick == 0)      clock_s -= $urandom_range(1, 100);
      else if (pick < 3)  clock_s += $urandom_range(50, 200);
      else                clock_s += $urandom_range(0, 8);
      queue_request(c, k, 1'($urandom), 1'($urandom), clock_s);
    end
  endtask

  // Wait until every request is accepted and answered
  task automatic settle_table();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  task automatic write_age_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    age_limit_we   <= 1'b1;
    age_limit_data <= v;
    @(posedge clk);
    age_limit_we   <= 1'b0;
    age_limit_m     = v;
  endtask

  // Request driver
  always @(posedge clk) begin
    table_outcome_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        res = apply_command(on_wire);
        outcome_q.push_back(res);
        cmd_count[on_wire.cmd]++;
        if (res.status == ST_FULL) full_count++;
        if (on_wire.cmd == CMD_SWEEP) aged_count += res.removed;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_wire         = pending_q.pop_front();
          in_valid       <= 1'b1;
          command        <= on_wire.cmd;
          address_key    <= on_wire.key;
          block_flag     <= on_wire.blk;
          check_existing <= on_wire.chk;
          now_seconds    <= on_wire.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    table_outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = outcome_q.pop_front();
          if (found !== want.found) report_mismatch("found", found, want.found);
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (removed_count !== want.removed)
            report_mismatch("removed_count", removed_count, want.removed);
        end
        result_count++;
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Stimulus and phase control
  initial begin
    logic [LIMIT_W-1:0] limits[6];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_live[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_blk[i]   = 1'b0;
      slot_stamp[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: absent keys, insert variants, aging edges, time wrap
    queue_request(CMD_TOUCH,  32'h0000_0000, 1'b0, 1'b0, 32'd0);
    queue_request(CMD_REMOVE, 32'h0000_0000, 1'b1, 1'b1, 32'd0);
    queue_request(CMD_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 32'd0);
    queue_request(CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 32'd100);
    queue_request(CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd100);
    queue_request(CMD_INSERT, 32'h0000_0000, 1'b0, 1'b0, 32'd110);
    queue_request(CMD_INSERT, 32'h0000_0000, 1'b0, 1'b1, 32'd120);
    queue_request(CMD_TOUCH,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'd130);
    queue_request(CMD_SWEEP,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'd179);
    queue_request(CMD_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 32'd190);
    queue_request(CMD_INSERT, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'hFFFF_FFF0);
    queue_request(CMD_INSERT, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'h0000_0010);
    queue_request(CMD_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0020);
    queue_request(CMD_TOUCH,  32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0000_0100);
    queue_request(CMD_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0050);
    queue_request(CMD_INSERT, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0060);
    queue_request(CMD_REMOVE, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0061);
    queue_request(CMD_REMOVE, 32'h1234_5678, 1'b1, 1'b0, 32'h0000_0062);
    queue_request(CMD_TOUCH,  32'hDEAD_BEEF, 1'b1, 1'b1, 32'h8000_0000);
    queue_request(CMD_SWEEP,  32'h0000_0000, 1'b0, 1'b0, 32'hFFFF_FFFF);
    settle_table();

    // random phases; the first runs at the reset limit with no idling
    limits = '{AGE_LIMIT_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(1, 300)), 16'd1,
               16'($urandom)};
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_age_limit(limits[p]);
      idle_pct = (p == 0) ? 0 : 27;
      clock_s  = (p == 1) ? 32'hFFFF_FF80 : $urandom;
      queue_random(100, p == 2);
      settle_table();
    end

    repeat (TABLE_ENTRIES + 10) @(posedge clk);
    if (outcome_q.size() != 0) report_mismatch("results still outstanding", 0,
                                               outcome_q.size());
    $display("run covered %0d results: %0d touch, %0d insert, %0d remove, %0d sweep",
             result_count, cmd_count[CMD_TOUCH], cmd_count[CMD_INSERT],
             cmd_count[CMD_REMOVE], cmd_count[CMD_SWEEP]);
    $display("inserts dropped on a full table: %0d, entries aged out: %0d, mismatches: %0d",
             full_count, aged_count, error_count);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/abtwa_pkg.sv
hw/rtl/abtwa_cell.sv
hw/rtl/address_block_table_with_aging.sv
dv/tb_top.sv
